[src/phased_tick_pacer_core_assert.svh]
// Assertion macros for the tick pacer
`ifndef PHASED_TICK_PACER_CORE_ASSERT_SVH
`define PHASED_TICK_PACER_CORE_ASSERT_SVH

// Clocked check, held off while in reset
`define PTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true
`define PTP_ASSERT_NEVER(lbl, cond, msg) \
  `PTP_ASSERT(lbl, !(cond), msg)

`endif

[src/ptp_pkg.sv]
package ptp_pkg;

  localparam int unsigned FAST_COUNTERS = 4;
  localparam int unsigned SLOT_TIMERS   = 8;

  localparam int unsigned FcIdxW = (FAST_COUNTERS > 1) ? $clog2(FAST_COUNTERS) : 1;
  localparam int unsigned StIdxW = (SLOT_TIMERS > 1) ? $clog2(SLOT_TIMERS) : 1;

  localparam logic [3:0]  PHASE_LAST  = 4'd9;
  localparam logic [3:0]  LED_PHASE   = 4'd5;
  localparam logic [3:0]  MS_PHASE    = 4'd9;
  localparam logic [4:0]  LED_SUB_LAST = 5'd24;
  localparam logic [4:0]  LED_STEP_AT = 5'd17;
  localparam logic [4:0]  LED_LOW     = 5'd2;
  localparam logic [4:0]  LED_HIGH    = 5'd24;
  localparam logic [4:0]  LED_RESET_LEVEL = 5'd20;
  localparam logic [15:0] MS_LAST     = 16'd59999;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 120;

  typedef enum logic [2:0] {
    KindTick = 3'd0,
    KindSet  = 3'd1,
    KindRead = 3'd2,
    KindLoad = 3'd3,
    KindArm  = 3'd4
  } kind_e;

  typedef enum logic [0:0] {
    CfgTx1Period = 1'b0,
    CfgTx2Period = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  target_index;
    logic [31:0] load_value;
  } ptp_item_t;

  typedef struct packed {
    logic [15:0] tx1_period;
    logic [15:0] tx2_period;
  } ptp_cfg_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [63:0] tick_total;
    logic [15:0] ms_count;
    logic        task_fire;
    logic [2:0]  task_slot;
    logic        led_lit;
    logic        tx1_fire;
    logic        tx2_fire;
  } ptp_result_t;

endpackage

[src/ptp_in_stage.sv]
module ptp_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  ptp_pkg::ptp_item_t   item_i,
  input  logic                 take_i,
  output logic                 valid_o,
  output ptp_pkg::ptp_item_t   item_o
);

  logic               valid_q;
  ptp_pkg::ptp_item_t item_q;
  logic               load;

  assign s_tready_o = !valid_q || take_i;
  assign load       = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[src/ptp_engine.sv]
`include "phased_tick_pacer_core_assert.svh"

module ptp_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptp_pkg::ptp_cfg_t    cfg_i,
  input  logic                 in_valid_i,
  input  ptp_pkg::ptp_item_t   item_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ptp_pkg::ptp_result_t result_o
);

  logic [63:0] tick_q, tick_d;
  logic [3:0]  phase_q, phase_d;
  logic [15:0] ms_q, ms_d;
  logic [4:0]  ms_sub_q, ms_sub_d;
  logic [31:0] fast_q [ptp_pkg::FAST_COUNTERS];
  logic [31:0] fast_d [ptp_pkg::FAST_COUNTERS];
  logic [31:0] slot_q [ptp_pkg::SLOT_TIMERS];
  logic [31:0] slot_d [ptp_pkg::SLOT_TIMERS];
  logic [4:0]  led_level_q, led_level_d;
  logic        led_falling_q, led_falling_d;
  logic [4:0]  led_time_q, led_time_d;
  logic        led_state_q, led_state_d;
  logic [15:0] tx1_q, tx1_d;
  logic [15:0] tx2_q, tx2_d;

  logic                 out_valid_q;
  ptp_pkg::ptp_result_t res_q, res_d;
  logic                 advance;

  logic                            fc_hit, st_hit, slot_phase;
  logic [ptp_pkg::FcIdxW-1:0]      fc_idx;
  logic [ptp_pkg::StIdxW-1:0]      st_idx, st_cur;
  logic [31:0]                     slot_dec;
  logic [4:0]                      lvl_step, time_led;

  assign advance     = in_valid_i && (!out_valid_q || out_ready_i);
  assign take_o      = advance;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  assign fc_idx     = item_i.target_index[ptp_pkg::FcIdxW-1:0];
  assign st_idx     = item_i.target_index[ptp_pkg::StIdxW-1:0];
  assign fc_hit     = {1'b0, item_i.target_index} < 4'(ptp_pkg::FAST_COUNTERS);
  assign st_hit     = {1'b0, item_i.target_index} < 4'(ptp_pkg::SLOT_TIMERS);
  assign slot_phase = {1'b0, phase_q} < 5'(ptp_pkg::SLOT_TIMERS);
  assign st_cur     = phase_q[ptp_pkg::StIdxW-1:0];
  assign slot_dec   = slot_q[st_cur] - 32'd1;
  assign lvl_step   = led_falling_q ? (led_level_q - 5'd1) : (led_level_q + 5'd1);

  always_comb begin
    tick_d        = tick_q;
    phase_d       = phase_q;
    ms_d          = ms_q;
    ms_sub_d      = ms_sub_q;
    fast_d        = fast_q;
    slot_d        = slot_q;
    led_level_d   = led_level_q;
    led_falling_d = led_falling_q;
    led_time_d    = led_time_q;
    led_state_d   = led_state_q;
    tx1_d         = tx1_q;
    tx2_d         = tx2_q;
    time_led      = led_time_q;
    res_d         = '0;

    case (ptp_pkg::kind_e'(item_i.kind))
      ptp_pkg::KindTick: begin
        tick_d = tick_q + 64'd1;
        for (int i = 0; i < ptp_pkg::FAST_COUNTERS; i++) begin
          if (fast_q[i] != 32'd0) begin
            fast_d[i] = fast_q[i] - 32'd1;
          end
        end
        if (slot_phase && slot_q[st_cur] != 32'd0) begin
          slot_d[st_cur] = slot_dec;
          if (slot_dec == 32'd0) begin
            res_d.task_fire = 1'b1;
            res_d.task_slot = 3'(phase_q);
          end
        end
        if (phase_q == ptp_pkg::LED_PHASE) begin
          if (ms_sub_q == ptp_pkg::LED_STEP_AT) begin
            led_level_d = lvl_step;
            if (led_falling_q) begin
              led_falling_d = !(lvl_step < ptp_pkg::LED_LOW);
            end else begin
              led_falling_d = lvl_step > ptp_pkg::LED_HIGH;
            end
            time_led = lvl_step;
          end
          led_time_d = time_led;
          if (time_led != 5'd0) begin
            led_time_d  = time_led - 5'd1;
            led_state_d = (time_led - 5'd1) != 5'd0;
          end
        end
        if (phase_q == ptp_pkg::MS_PHASE) begin
          ms_d     = (ms_q == ptp_pkg::MS_LAST) ? 16'd0 : ms_q + 16'd1;
          ms_sub_d = (ms_sub_q == ptp_pkg::LED_SUB_LAST) ? 5'd0 : ms_sub_q + 5'd1;
        end
        phase_d = (phase_q == ptp_pkg::PHASE_LAST) ? 4'd0 : phase_q + 4'd1;
        if (tx1_q != 16'd0) begin
          tx1_d = tx1_q - 16'd1;
          if (tx1_q == 16'd1) begin
            tx1_d          = cfg_i.tx1_period;
            res_d.tx1_fire = 1'b1;
          end
        end
        if (tx2_q != 16'd0) begin
          tx2_d = tx2_q - 16'd1;
          if (tx2_q == 16'd1) begin
            tx2_d          = cfg_i.tx2_period;
            res_d.tx2_fire = 1'b1;
          end
        end
      end
      ptp_pkg::KindSet: begin
        if (fc_hit) begin
          fast_d[fc_idx] = item_i.load_value;
        end
      end
      ptp_pkg::KindRead: begin
        if (fc_hit) begin
          res_d.read_value = fast_q[fc_idx];
        end
      end
      ptp_pkg::KindLoad: begin
        if (st_hit) begin
          slot_d[st_idx] = item_i.load_value;
        end
      end
      ptp_pkg::KindArm: begin
        if (item_i.target_index == 3'd0) begin
          tx1_d = item_i.load_value[15:0];
        end else if (item_i.target_index == 3'd1) begin
          tx2_d = item_i.load_value[15:0];
        end
      end
      default: begin
      end
    endcase

    res_d.tick_total = tick_d;
    res_d.ms_count   = ms_d;
    res_d.led_lit    = led_state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q        <= '0;
      phase_q       <= '0;
      ms_q          <= '0;
      ms_sub_q      <= '0;
      fast_q        <= '{default: '0};
      slot_q        <= '{default: '0};
      led_level_q   <= ptp_pkg::LED_RESET_LEVEL;
      led_falling_q <= 1'b0;
      led_time_q    <= '0;
      led_state_q   <= 1'b0;
      tx1_q         <= '0;
      tx2_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (advance) begin
        tick_q        <= tick_d;
        phase_q       <= phase_d;
        ms_q          <= ms_d;
        ms_sub_q      <= ms_sub_d;
        fast_q        <= fast_d;
        slot_q        <= slot_d;
        led_level_q   <= led_level_d;
        led_falling_q <= led_falling_d;
        led_time_q    <= led_time_d;
        led_state_q   <= led_state_d;
        tx1_q         <= tx1_d;
        tx2_q         <= tx2_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  `PTP_ASSERT(a_phase_range, phase_q <= ptp_pkg::PHASE_LAST, "phase out of range")
  `PTP_ASSERT(a_ms_range, ms_q <= ptp_pkg::MS_LAST, "ms count out of range")
  `PTP_ASSERT(a_led_range, led_level_q >= 5'd1 && led_level_q <= 5'd25, "LED level out of range")
  `PTP_ASSERT(a_tick_inc,
    advance && item_i.kind == ptp_pkg::KindTick |=> tick_q == $past(tick_q) + 64'd1,
    "tick count did not advance")
  `PTP_ASSERT(a_no_fire_idle,
    advance && item_i.kind != ptp_pkg::KindTick |=> !res_q.task_fire && !res_q.tx1_fire
      && !res_q.tx2_fire, "fire on a non-tick transaction")
  `PTP_ASSERT_NEVER(a_hold_stalled, out_valid_q && !out_ready_i && take_o,
    "transaction taken over a stalled result")

endmodule

[src/phased_tick_pacer_core.sv]
// Tick pacer for a 100 us system tick. Each input transaction is a tick, a fast
// counter write or read, a slot timer load or a transmit counter arm (kind in
// tuser). A tick advances the 64-bit tick count, decrements the fast counters,
// services slot timer N in phase N, steps the breathing LED in phase 5, bumps
// the millisecond count in phase 9 and runs both transmit reload counters.
// One transaction is accepted every clock cycle while the output is not stalled;
// each result passes through the input register and then the result register,
// with the whole update done in one pass between them. A stalled result holds
// the input once both registers are full. Transmit periods are written through
// the configuration port (index 0 channel one, 1 channel two); the user must
// write them only while the block is idle, which the block itself does not enforce.
module phased_tick_pacer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [2:0] target_index, [34:3] load_value
  input  logic [ptp_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [2:0] kind
  input  logic [2:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] read_value, [95:32] tick_total, [111:96] ms_count, [112] task_fire,
  // [115:113] task_slot, [116] led_lit, [117] tx1_fire, [118] tx2_fire
  output logic [ptp_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  ptp_pkg::ptp_cfg_t    cfg_q;
  ptp_pkg::ptp_item_t   item_in, item_reg;
  ptp_pkg::ptp_result_t result;
  logic                 item_valid, take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (ptp_pkg::cfg_reg_e'(cfg_index_i))
        ptp_pkg::CfgTx1Period: cfg_q.tx1_period <= cfg_data_i;
        ptp_pkg::CfgTx2Period: cfg_q.tx2_period <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign item_in.kind         = s_axis_tuser_i;
  assign item_in.target_index = s_axis_tdata_i[2:0];
  assign item_in.load_value   = s_axis_tdata_i[34:3];

  ptp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .item_i     (item_in),
    .take_i     (take),
    .valid_o    (item_valid),
    .item_o     (item_reg)
  );

  ptp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (item_valid),
    .item_i      (item_reg),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result)
  );

  assign m_axis_tdata_o = {1'b0, result.tx2_fire, result.tx1_fire, result.led_lit,
                           result.task_slot, result.task_fire, result.ms_count,
                           result.tick_total, result.read_value};

endmodule

[tb/sv/phased_tick_pacer_core_tb.sv]
`timescale 1ns / 1ps

module phased_tick_pacer_core_tb;

  localparam int          CLK_HALF       = 4;
  localparam int          RST_CYCLES     = 9;
  localparam int          IDLE_MAX       = 6;
  localparam int          RX_HOLD_CYCLES = 60;
  localparam int          QUIET_LIMIT    = 1000;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          TX_CHANNELS    = 2;
  localparam int          MAX_REPORTS    = 10;
  localparam int          DIR_N          = 25;
  localparam int          LED_RUN_TICKS  = 80;
  localparam logic [2:0]  KIND_SPARE_LO  = 3'd5;
  localparam logic [2:0]  KIND_SPARE_HI  = 3'd7;
  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
  localparam logic [31:0] TOP_BIT        = 32'h8000_0000;

  typedef struct {
    logic [2:0]  kind;
    logic [2:0]  idx;
    logic [31:0] val;
    bit          typed;
    logic [31:0] exp_read;
  } dir_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_valid;
  logic [0:0]                   cfg_index;
  logic [15:0]                  cfg_data;
  logic                         s_valid;
  logic [ptp_pkg::InDataW-1:0]  s_tdata;
  logic [2:0]                   s_tuser;
  logic                         m_tready;
  logic                         cfg_ready_o;
  logic                         s_axis_tready_o;
  logic                         m_axis_tvalid_o;
  logic [ptp_pkg::OutDataW-1:0] m_axis_tdata_o;

  // pacer shadow state
  logic [63:0] tick_cnt;
  logic [3:0]  phase_cnt;
  logic [15:0] ms_cnt;
  logic [31:0] fast_cnt [ptp_pkg::FAST_COUNTERS];
  logic [31:0] slot_tmr [ptp_pkg::SLOT_TIMERS];
  logic [4:0]  led_level;
  logic        led_falling;
  logic [4:0]  led_time;
  logic        led_on;
  logic [15:0] tx_cnt [TX_CHANNELS];
  logic [15:0] tx_period [TX_CHANNELS];

  ptp_pkg::ptp_result_t due_results [$];
  dir_row_t             dir_rows [DIR_N];
  int unsigned          fail_cnt   = 0;
  int unsigned          report_cnt = 0;
  int unsigned          quiet_cnt  = 0;
  bit                   tx_idle_on = 1'b1;
  bit                   rx_idle_on = 1'b1;
  bit                   hold_req   = 1'b0;

  phased_tick_pacer_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic ptp_pkg::ptp_result_t advance_pacer(logic [2:0] kind, logic [2:0] idx,
                                                         logic [31:0] val);
    ptp_pkg::ptp_result_t res;
    logic [1:0]           fired;
    res   = '0;
    fired = '0;
    case (kind)
      ptp_pkg::KindTick: begin
        tick_cnt++;
        for (int i = 0; i < ptp_pkg::FAST_COUNTERS; i++) begin
          if (fast_cnt[i] != 0) fast_cnt[i]--;
        end
        if (phase_cnt < ptp_pkg::SLOT_TIMERS && slot_tmr[phase_cnt] != 0) begin
          slot_tmr[phase_cnt]--;
          if (slot_tmr[phase_cnt] == 0) begin
            res.task_fire = 1'b1;
            res.task_slot = phase_cnt[2:0];
          end
        end
        if (phase_cnt == ptp_pkg::LED_PHASE) begin
          if (ms_cnt % (ptp_pkg::LED_SUB_LAST + 16'd1) == ptp_pkg::LED_STEP_AT) begin
            if (led_falling) begin
              led_level--;
              if (led_level < ptp_pkg::LED_LOW) led_falling = 1'b0;
            end else begin
              led_level++;
              if (led_level > ptp_pkg::LED_HIGH) led_falling = 1'b1;
            end
            led_time = led_level;
          end
          if (led_time != 0) begin
            led_time--;
            led_on = (led_time != 0);
          end
        end
        if (phase_cnt == ptp_pkg::MS_PHASE)
          ms_cnt = (ms_cnt == ptp_pkg::MS_LAST) ? '0 : ms_cnt + 16'd1;
        phase_cnt = (phase_cnt == ptp_pkg::PHASE_LAST) ? '0 : phase_cnt + 4'd1;
        for (int c = 0; c < TX_CHANNELS; c++) begin
          if (tx_cnt[c] != 0) begin
            tx_cnt[c]--;
            if (tx_cnt[c] == 0) begin
              tx_cnt[c] = tx_period[c];
              fired[c]  = 1'b1;
            end
          end
        end
        res.tx1_fire = fired[0];
        res.tx2_fire = fired[1];
      end
      ptp_pkg::KindSet:  if (idx < ptp_pkg::FAST_COUNTERS) fast_cnt[idx] = val;
      ptp_pkg::KindRead: if (idx < ptp_pkg::FAST_COUNTERS) res.read_value = fast_cnt[idx];
      ptp_pkg::KindLoad: if (idx < ptp_pkg::SLOT_TIMERS) slot_tmr[idx] = val;
      ptp_pkg::KindArm:  if (idx < TX_CHANNELS) tx_cnt[idx[0]] = val[15:0];
      default: ;
    endcase
    res.tick_total = tick_cnt;
    res.ms_count   = ms_cnt;
    res.led_lit    = led_on;
    return res;
  endfunction

  task automatic send_item(logic [2:0] kind, logic [2:0] idx, logic [31:0] val,
                           bit typed, logic [31:0] exp_read);
    int                   gap;
    ptp_pkg::ptp_result_t want;
    gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {{(ptp_pkg::InDataW - 35){1'b0}}, val, idx};
    s_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = advance_pacer(kind, idx, val);
    if (typed) begin
      want            = '0;
      want.read_value = exp_read;
    end
    due_results.push_back(want);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(ptp_pkg::cfg_reg_e which, logic [15:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid <= 1'b0;
    tx_period[which] = data;
  endtask

  task automatic run_random(int n, int hold_at);
    int          r;
    logic [2:0]  kind;
    logic [2:0]  idx;
    logic [31:0] val;
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 55)      kind = ptp_pkg::KindTick;
      else if (r < 67) kind = ptp_pkg::KindSet;
      else if (r < 79) kind = ptp_pkg::KindRead;
      else if (r < 88) kind = ptp_pkg::KindLoad;
      else if (r < 95) kind = ptp_pkg::KindArm;
      else             kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      if ($urandom_range(0, 9) < 8) begin
        case (kind)
          ptp_pkg::KindSet, ptp_pkg::KindRead:
            idx = 3'($urandom_range(0, ptp_pkg::FAST_COUNTERS - 1));
          ptp_pkg::KindLoad: idx = 3'($urandom_range(0, ptp_pkg::SLOT_TIMERS - 1));
          ptp_pkg::KindArm:  idx = 3'($urandom_range(0, TX_CHANNELS - 1));
          default:           idx = 3'($urandom_range(0, 7));
        endcase
      end else begin
        idx = 3'($urandom_range(0, 7));
      end
      r = $urandom_range(0, 9);
      if (r < 5)       val = $urandom_range(0, 40);
      else if (r < 8)  val = $urandom;
      else if (r == 8) val = '0;
      else             val = $urandom_range(0, 1) ? ALL_ONES : TOP_BIT;
      send_item(kind, idx, val, 1'b0, '0);
    end
  endtask

  // sink side
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    ptp_pkg::ptp_result_t got;
    ptp_pkg::ptp_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.read_value = m_axis_tdata_o[31:0];
      got.tick_total = m_axis_tdata_o[95:32];
      got.ms_count   = m_axis_tdata_o[111:96];
      got.task_fire  = m_axis_tdata_o[112];
      got.task_slot  = m_axis_tdata_o[115:113];
      got.led_lit    = m_axis_tdata_o[116];
      got.tx1_fire   = m_axis_tdata_o[117];
      got.tx2_fire   = m_axis_tdata_o[118];
      if (due_results.size() == 0) begin
        fail_cnt++;
        if (report_cnt < MAX_REPORTS)
          $display("unexpected result transaction: %h", m_axis_tdata_o);
        report_cnt++;
      end else begin
        want = due_results.pop_front();
        if (got.read_value !== want.read_value || got.tick_total !== want.tick_total ||
            got.ms_count !== want.ms_count || got.task_fire !== want.task_fire ||
            got.task_slot !== want.task_slot || got.led_lit !== want.led_lit ||
            got.tx1_fire !== want.tx1_fire || got.tx2_fire !== want.tx2_fire) begin
          fail_cnt++;
          if (report_cnt < MAX_REPORTS) begin
            $display("mismatch: read %h/%h ticks %h/%h ms %0d/%0d task %b%0d/%b%0d",
                     want.read_value, got.read_value, want.tick_total, got.tick_total,
                     want.ms_count, got.ms_count, want.task_fire, want.task_slot,
                     got.task_fire, got.task_slot);
            $display("  led %b/%b tx1 %b/%b tx2 %b/%b (expected/actual)",
                     want.led_lit, got.led_lit, want.tx1_fire, got.tx1_fire,
                     want.tx2_fire, got.tx2_fire);
          end
          report_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni    <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_valid   <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;

    tick_cnt    = '0;
    phase_cnt   = '0;
    ms_cnt      = '0;
    led_level   = ptp_pkg::LED_RESET_LEVEL;
    led_falling = 1'b0;
    led_time    = '0;
    led_on      = 1'b0;
    for (int i = 0; i < ptp_pkg::FAST_COUNTERS; i++) fast_cnt[i] = '0;
    for (int i = 0; i < ptp_pkg::SLOT_TIMERS; i++) slot_tmr[i] = '0;
    for (int c = 0; c < TX_CHANNELS; c++) begin
      tx_cnt[c]    = '0;
      tx_period[c] = '0;
    end

    dir_rows = '{
      '{ptp_pkg::KindRead, 3'd0, 32'd0,         1'b1, 32'd0},
      '{ptp_pkg::KindRead, 3'd7, 32'd0,         1'b1, 32'd0},
      '{ptp_pkg::KindSet,  3'd0, ALL_ONES,      1'b1, 32'd0},
      '{ptp_pkg::KindRead, 3'd0, 32'd0,         1'b1, ALL_ONES},
      '{ptp_pkg::KindSet,  3'd3, 32'd1,         1'b1, 32'd0},
      '{ptp_pkg::KindSet,  3'd6, 32'h1234,      1'b1, 32'd0},
      '{ptp_pkg::KindRead, 3'd6, 32'd0,         1'b1, 32'd0},
      '{ptp_pkg::KindLoad, 3'd0, 32'd1,         1'b1, 32'd0},
      '{ptp_pkg::KindLoad, 3'd7, ALL_ONES,      1'b1, 32'd0},
      '{ptp_pkg::KindArm,  3'd0, 32'h0001_0002, 1'b1, 32'd0},
      '{ptp_pkg::KindArm,  3'd1, 32'd1,         1'b1, 32'd0},
      '{ptp_pkg::KindArm,  3'd5, 32'd7,         1'b1, 32'd0},
      '{KIND_SPARE_LO,     3'd0, ALL_ONES,      1'b1, 32'd0},
      '{KIND_SPARE_HI,     3'd7, ALL_ONES,      1'b1, 32'd0},
      '{ptp_pkg::KindTick, 3'd0, 32'd0,         1'b0, 32'd0},
      '{ptp_pkg::KindRead, 3'd3, 32'd0,         1'b0, 32'd0},
      '{ptp_pkg::KindRead, 3'd0, 32'd0,         1'b0, 32'd0},
      '{ptp_pkg::KindTick, 3'd7, ALL_ONES,      1'b0, 32'd0},
      '{ptp_pkg::KindLoad, 3'd2, 32'd1,         1'b0, 32'd0},
      '{ptp_pkg::KindTick, 3'd0, 32'd0,         1'b0, 32'd0},
      '{ptp_pkg::KindSet,  3'd1, 32'd0,         1'b0, 32'd0},
      '{ptp_pkg::KindLoad, 3'd3, 32'd0,         1'b0, 32'd0},
      '{ptp_pkg::KindSet,  3'd2, TOP_BIT,       1'b0, 32'd0},
      '{ptp_pkg::KindTick, 3'd0, 32'd0,         1'b0, 32'd0},
      '{ptp_pkg::KindRead, 3'd2, 32'd0,         1'b0, 32'd0}
    };

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_write(ptp_pkg::CfgTx1Period, 16'd3, 1'b0);
    cfg_write(ptp_pkg::CfgTx2Period, 16'd0, 1'b1);
    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].val,
                dir_rows[i].typed, dir_rows[i].exp_read);
    wait_drained();

    cfg_write(ptp_pkg::CfgTx1Period, 16'hFFFF, 1'b0);
    cfg_write(ptp_pkg::CfgTx2Period, 16'd1, 1'b1);
    run_random(150, -1);
    wait_drained();

    // long sink hold while the source keeps offering
    cfg_write(ptp_pkg::CfgTx1Period, 16'd7, 1'b0);
    cfg_write(ptp_pkg::CfgTx2Period, 16'd13, 1'b1);
    run_random(150, 40);
    wait_drained();

    // unbroken tick run at full rate on both sides
    cfg_write(ptp_pkg::CfgTx1Period, 16'd1, 1'b0);
    cfg_write(ptp_pkg::CfgTx2Period, 16'hFFFF, 1'b1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_item(ptp_pkg::KindArm, 3'd0, 32'd1, 1'b0, '0);
    send_item(ptp_pkg::KindArm, 3'd1, 32'd5, 1'b0, '0);
    send_item(ptp_pkg::KindLoad, 3'd4, 32'd30, 1'b0, '0);
    send_item(ptp_pkg::KindSet, 3'd1, 32'd50, 1'b0, '0);
    for (int k = 0; k < LED_RUN_TICKS; k++)
      send_item(ptp_pkg::KindTick, 3'($urandom_range(0, 7)), $urandom, 1'b0, '0);
    send_item(ptp_pkg::KindRead, 3'd1, 32'd0, 1'b0, '0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random(140, -1);

    wait_drained();
    if (due_results.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/ptp_pkg.sv
src/ptp_in_stage.sv
src/ptp_engine.sv
src/phased_tick_pacer_core.sv
tb/sv/phased_tick_pacer_core_tb.sv
